/* rtl/smeu_pkg.sv */
// Package for the stack machine execute unit: sizes, opcodes, error codes,
// and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none
package smeu_pkg;
  localparam int STACK_DEPTH = 1024;
  localparam int NUM_REGS    = 4;
  localparam int MEM_WORDS   = 32768;
  localparam int PC_BITS     = 16;
  localparam int SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int SA_W  = $clog2(STACK_DEPTH);
  localparam int RI_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int MA_W  = $clog2(MEM_WORDS);

  localparam logic [4:0] OP_HLT = 5'd0, OP_PUSH = 5'd1, OP_ADD = 5'd2, OP_SUB = 5'd3,
    OP_MUL = 5'd4, OP_DIV = 5'd5, OP_OUT = 5'd6, OP_IN = 5'd7, OP_SQRT = 5'd8,
    OP_JMP = 5'd9, OP_JB = 5'd10, OP_JBE = 5'd11, OP_JA = 5'd12, OP_JAE = 5'd13,
    OP_JE = 5'd14, OP_JNE = 5'd15, OP_CALL = 5'd16, OP_RET = 5'd17,
    OP_PUSHR = 5'd18, OP_POPR = 5'd19, OP_PUSHM = 5'd20, OP_POPM = 5'd21;

  localparam logic [3:0] ERR_OK = 4'd0, ERR_DIV0 = 4'd1, ERR_NSQRT = 4'd2,
    ERR_UNDER = 4'd3, ERR_OVER = 4'd4, ERR_REG = 4'd5, ERR_ADDR = 4'd6,
    ERR_OPC = 4'd7, ERR_RET = 4'd8;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // latch the item and read the stack tops / register
    logic fetch;    // capture memory read data and the product
    logic exec;     // check faults, commit simple ops or start the long unit
    logic finish;   // commit a divide or sqrt result
  } smeu_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic long_op;  // exec started the iterative unit
    logic long_done;
  } smeu_sts_t;
endpackage
`default_nettype wire

/* rtl/smeu_ctrl.sv */
// Controller state machine for the stack machine execute unit.
// Depends on smeu_pkg.
`default_nettype none
module smeu_ctrl import smeu_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_fire,
  input  wire logic      out_free,
  input  wire smeu_sts_t sts,
  output smeu_cmd_t      cmd,
  output logic           in_ready,
  output logic           res_load
);
  localparam logic [2:0] S_IDLE = 3'd0, S_FETCH = 3'd1, S_EXEC = 3'd2,
    S_LONG = 3'd3, S_DONE = 3'd4;
  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    res_load = 1'b0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
        if (in_fire) state_nxt = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.exec = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Exec result is in; a long op keeps iterating before it reports.
        if (sts.long_op) state_nxt = S_LONG;
        else begin
          res_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_LONG: begin
        if (sts.long_done) begin
          cmd.finish = 1'b1;
          res_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

/* rtl/smeu_iter.sv */
// Shared iterative unit: restoring unsigned divide and bitwise integer
// square root, one bit of root or one quotient bit a cycle. Depends on smeu_pkg.
`default_nettype none
module smeu_iter import smeu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        is_sqrt,
  input  wire logic [31:0] opa,
  input  wire logic [31:0] opb,
  output logic             busy,
  output logic             done,
  output logic [31:0]      result
);
  logic        busy_r, busy_nxt, sq_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r, bit_r, bit_nxt;
  logic [32:0] diff;
  logic [31:0] sqt;

  assign busy = busy_r;
  assign done = busy_r && (cnt_r == 6'd0);
  assign result = quo_r;

  always_comb begin
    rem_nxt = rem_r; quo_nxt = quo_r; bit_nxt = bit_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r;
    diff = '0; sqt = '0;
    if (start) begin
      busy_nxt = 1'b1;
      rem_nxt  = is_sqrt ? opa : 32'd0;
      quo_nxt  = is_sqrt ? 32'd0 : opa;
      bit_nxt  = 32'h4000_0000;
      cnt_nxt  = is_sqrt ? 6'd16 : 6'd32;
    end else if (busy_r) begin
      if (cnt_r == 6'd0) busy_nxt = 1'b0;
      else begin
        cnt_nxt = cnt_r - 6'd1;
        if (sq_r) begin
          sqt = quo_r + bit_r;
          if (rem_r >= sqt) begin
            rem_nxt = rem_r - sqt;
            quo_nxt = (quo_r >> 1) + bit_r;
          end else quo_nxt = quo_r >> 1;
          bit_nxt = bit_r >> 2;
        end else begin
          diff = {rem_r, quo_r[31]} - {1'b0, den_r};
          if (!diff[32]) begin
            rem_nxt = diff[31:0];
            quo_nxt = {quo_r[30:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[30:0], quo_r[31]};
            quo_nxt = {quo_r[30:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else busy_r <= busy_nxt;
    cnt_r <= cnt_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt; bit_r <= bit_nxt;
    if (start) begin
      sq_r  <= is_sqrt;
      den_r <= opb;
    end
  end
endmodule
`default_nettype wire

/* rtl/smeu_dpath.sv */
// Datapath: stacks, registers, word RAM, program counter, ALU and faults.
// Depends on smeu_pkg and smeu_iter.
`default_nettype none
module smeu_dpath import smeu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire smeu_cmd_t   cmd,
  input  wire logic [4:0]  func,
  input  wire logic [31:0] argument,
  input  wire logic [31:0] in_value,
  output smeu_sts_t        sts,
  output logic [PC_BITS-1:0] r_pc,
  output logic             r_ov,
  output logic [31:0]      r_oval,
  output logic             r_halt,
  output logic [3:0]       r_err
);
  logic [31:0] dstk [STACK_DEPTH];
  logic [PC_BITS-1:0] rstk [STACK_DEPTH];
  logic [31:0] wmem [MEM_WORDS];
  // Word RAM reset is all zeros: a sweep clears it after reset.
  logic [MA_W:0] clr_r;
  logic clr_busy;
  assign clr_busy = !clr_r[MA_W];

  logic [SP_W-1:0] dsp_r, rsp_r;
  logic [31:0] gpr_r [NUM_REGS];
  logic [PC_BITS-1:0] pc_r;
  logic halt_r;
  logic [4:0] op_r;
  logic [31:0] arg_r, inv_r, b_r, a_r, mrd_r, reg_r;
  logic [PC_BITS-1:0] rtop_r;
  logic regok_r;
  logic [31:0] prod_r;
  logic [31:0] ma, mb;
  logic na_r, nb_r, sq_r;

  logic [SA_W-1:0] ia, ib;
  logic [RI_W-1:0] ri;
  assign ia = SA_W'(dsp_r - SP_W'(2));
  assign ib = SA_W'(dsp_r - SP_W'(1));
  assign ri = arg_r[RI_W-1:0];

  // Exec decisions.
  logic [3:0] err;
  logic [PC_BITS-1:0] npc, pc1, pc2, tgt;
  logic do_push, do_pop1, do_pop2, do_wrtop, do_halt, do_ov, do_rpush, do_rpop;
  logic do_gw, do_mw, start_long, take;
  logic [31:0] pval, tval;
  logic addr_ok;
  logic lt_ab, lt_ba;

  assign pc1 = pc_r + PC_BITS'(1);
  assign pc2 = pc_r + PC_BITS'(2);
  assign tgt = arg_r[PC_BITS-1:0];
  assign addr_ok = reg_r < 32'(MEM_WORDS);
  assign lt_ab = $signed(a_r) < $signed(b_r);
  assign lt_ba = $signed(b_r) < $signed(a_r);
  assign ma = a_r[31] ? -a_r : a_r;
  assign mb = b_r[31] ? -b_r : b_r;

  always_comb begin
    err = ERR_OK; npc = pc1;
    do_push = 1'b0; do_pop1 = 1'b0; do_pop2 = 1'b0; do_wrtop = 1'b0;
    do_halt = 1'b0; do_ov = 1'b0; do_rpush = 1'b0; do_rpop = 1'b0;
    do_gw = 1'b0; do_mw = 1'b0; start_long = 1'b0; take = 1'b0;
    pval = arg_r; tval = prod_r;
    if (halt_r) npc = pc_r;
    else begin
      case (op_r)
        OP_HLT: begin do_halt = 1'b1; npc = pc_r; end
        OP_PUSH, OP_IN: begin
          if (dsp_r >= SP_W'(STACK_DEPTH)) err = ERR_OVER;
          else begin
            do_push = 1'b1;
            pval = (op_r == OP_PUSH) ? arg_r : inv_r;
            if (op_r == OP_PUSH) npc = pc2;
          end
        end
        OP_OUT: begin
          if (dsp_r < SP_W'(1)) err = ERR_UNDER;
          else begin do_pop1 = 1'b1; do_ov = 1'b1; end
        end
        OP_SQRT: begin
          if (dsp_r < SP_W'(1)) err = ERR_UNDER;
          else if (b_r[31]) err = ERR_NSQRT;
          else start_long = 1'b1;
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          if (dsp_r < SP_W'(2)) err = ERR_UNDER;
          else if (op_r == OP_DIV && b_r == 32'd0) err = ERR_DIV0;
          else if (op_r == OP_DIV) start_long = 1'b1;
          else begin
            do_pop1 = 1'b1; do_wrtop = 1'b1;
            tval = (op_r == OP_ADD) ? a_r + b_r :
                   (op_r == OP_SUB) ? a_r - b_r : prod_r;
          end
        end
        OP_JMP: npc = tgt;
        OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE: begin
          if (dsp_r < SP_W'(2)) err = ERR_UNDER;
          else begin
            do_pop2 = 1'b1;
            case (op_r)
              OP_JB:  take = lt_ab;
              OP_JBE: take = !lt_ba;
              OP_JA:  take = lt_ba;
              OP_JAE: take = !lt_ab;
              OP_JE:  take = a_r == b_r;
              default: take = a_r != b_r;
            endcase
            npc = take ? tgt : pc2;
          end
        end
        OP_CALL: begin
          if (rsp_r >= SP_W'(STACK_DEPTH)) err = ERR_OVER;
          else begin do_rpush = 1'b1; npc = tgt; end
        end
        OP_RET: begin
          if (rsp_r == '0) err = ERR_RET;
          else begin do_rpop = 1'b1; npc = rtop_r; end
        end
        OP_PUSHR, OP_POPR, OP_PUSHM, OP_POPM: begin
          if (!regok_r) err = ERR_REG;
          else if ((op_r == OP_PUSHM || op_r == OP_POPM) && !addr_ok) err = ERR_ADDR;
          else if (op_r == OP_PUSHR || op_r == OP_PUSHM) begin
            if (dsp_r >= SP_W'(STACK_DEPTH)) err = ERR_OVER;
            else begin
              do_push = 1'b1;
              pval = (op_r == OP_PUSHR) ? reg_r : mrd_r;
            end
          end else begin
            if (dsp_r < SP_W'(1)) err = ERR_UNDER;
            else begin
              do_pop1 = 1'b1;
              if (op_r == OP_POPR) do_gw = 1'b1; else do_mw = 1'b1;
            end
          end
          if (err == ERR_OK) npc = pc2;
        end
        default: err = ERR_OPC;
      endcase
      if (err != ERR_OK) begin
        npc = pc_r;
        do_push = 1'b0; do_pop1 = 1'b0; do_pop2 = 1'b0; do_wrtop = 1'b0;
        do_ov = 1'b0; do_rpush = 1'b0; do_rpop = 1'b0; do_gw = 1'b0;
        do_mw = 1'b0; start_long = 1'b0;
      end
    end
  end

  logic it_busy, it_done;
  logic [31:0] it_res, fin;
  smeu_iter u_iter (
    .clk(clk), .rst_n(rst_n), .start(cmd.exec && start_long),
    .is_sqrt(op_r == OP_SQRT), .opa(op_r == OP_SQRT ? b_r : ma), .opb(mb),
    .busy(it_busy), .done(it_done), .result(it_res)
  );
  assign sts.long_op = it_busy;
  assign sts.long_done = it_done;
  assign fin = (!sq_r && (na_r != nb_r)) ? -it_res : it_res;

  // Stack top write port (push or replace top) and commit.
  always_ff @(posedge clk) begin
    if (cmd.exec && do_push) dstk[SA_W'(dsp_r)] <= pval;
    else if (cmd.exec && do_wrtop) dstk[ia] <= tval;
    else if (cmd.finish) dstk[sq_r ? ib : ia] <= fin;
    if (cmd.exec && do_rpush) rstk[SA_W'(rsp_r)] <= pc2;
    if (clr_busy) wmem[clr_r[MA_W-1:0]] <= 32'd0;
    else if (cmd.exec && do_mw) wmem[reg_r[MA_W-1:0]] <= b_r;
    if (cmd.load) begin
      b_r <= dstk[ib]; a_r <= dstk[ia];
      rtop_r <= rstk[SA_W'(rsp_r - SP_W'(1))];
    end
    if (cmd.fetch) mrd_r <= wmem[reg_r[MA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= func; arg_r <= argument; inv_r <= in_value;
      regok_r <= argument < 32'(NUM_REGS);
      reg_r <= gpr_r[argument[RI_W-1:0]];
    end
    if (cmd.fetch) prod_r <= a_r * b_r;
    if (cmd.exec) begin
      na_r <= a_r[31]; nb_r <= b_r[31]; sq_r <= op_r == OP_SQRT;
      r_oval <= do_ov ? b_r : 32'd0;
      r_ov <= do_ov;
      r_err <= err;
      r_pc <= npc;
    end
    if (!rst_n) begin
      clr_r <= '0; dsp_r <= '0; rsp_r <= '0; pc_r <= '0; halt_r <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) gpr_r[i] <= '0;
    end else begin
      if (clr_busy) clr_r <= clr_r + (MA_W+1)'(1);
      if (cmd.exec) begin
        if (!start_long) pc_r <= npc; else pc_r <= pc1;
        if (do_halt) halt_r <= 1'b1;
        if (do_push) dsp_r <= dsp_r + SP_W'(1);
        if (do_pop1) dsp_r <= dsp_r - SP_W'(1);
        if (do_pop2) dsp_r <= dsp_r - SP_W'(2);
        if (do_rpush) rsp_r <= rsp_r + SP_W'(1);
        if (do_rpop) rsp_r <= rsp_r - SP_W'(1);
        if (do_gw) gpr_r[ri] <= b_r;
      end
      if (cmd.finish && !sq_r) dsp_r <= dsp_r - SP_W'(1);
    end
  end
  assign r_halt = halt_r;
endmodule
`default_nettype wire

/* rtl/stack_machine_execute_unit.sv */
// Top level of the stack machine execute unit: stream ports, output register.
// Depends on smeu_pkg, smeu_ctrl, smeu_dpath.
// An accepted word goes through the fetch, execute and done states before its
// result is loaded; DIV and SQRT first iterate in the shared unit.
// One instruction at a time: no new word is accepted until the result is loaded;
// a result not yet taken holds the next one at execute.
// After reset the word RAM is cleared; no word is accepted until that is through.
`default_nettype none
module stack_machine_execute_unit import smeu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // func[4:0], argument[36:5], in_value[68:37]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata   // next_pc, out_valid, out_value, halted, error
);
  smeu_cmd_t cmd;
  smeu_sts_t sts;
  logic rdy, res_load, busy_clr;
  logic [PC_BITS-1:0] r_pc;
  logic r_ov, r_halt;
  logic [31:0] r_oval;
  logic [3:0] r_err;
  logic ov_r;
  logic [55:0] od_r;

  smeu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid && in_tready),
    .out_free(!ov_r || out_tready), .sts(sts), .cmd(cmd), .in_ready(rdy),
    .res_load(res_load)
  );
  smeu_dpath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .func(in_tdata[4:0]),
    .argument(in_tdata[36:5]), .in_value(in_tdata[68:37]), .sts(sts),
    .r_pc(r_pc), .r_ov(r_ov), .r_oval(r_oval), .r_halt(r_halt), .r_err(r_err)
  );

  // Wait out the word RAM clear after reset before accepting input.
  logic [MA_W:0] wait_r;
  assign busy_clr = !wait_r[MA_W];
  assign in_tready = rdy && !busy_clr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0; wait_r <= '0;
    end else begin
      if (busy_clr) wait_r <= wait_r + (MA_W+1)'(1);
      if (res_load) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
    if (res_load)
      od_r <= {2'b0, r_err, r_halt, r_oval, r_ov, 16'(r_pc)};
  end
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
endmodule
`default_nettype wire
